### src/positional_list_deque_unit_assert.svh
// Assertion macros for the positional list deque unit.
`ifndef POSITIONAL_LIST_DEQUE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_DEQUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clk edge out of reset.
`define PLDQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PLDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PLDQ_ASSERT_IMPL(lbl, ante, cons, msg)
`define PLDQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### src/pldq_pkg.sv
// Types and codes shared by the positional list deque unit.
package pldq_pkg;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_INSERT     = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_POP_BACK   = 3'd4,
    REQ_REMOVE     = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_RESULT = 1'b1
  } state_t;

  typedef struct packed {
    logic        [2:0]  req_type;
    logic        [7:0]  position;
    logic signed [31:0] item_value;
  } in_req_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic        [6:0]  count;
    logic               is_empty;
  } out_rsp_t;

endpackage

### src/pldq_cell.sv
// One storage cell of the shifting list chain.
module pldq_cell import pldq_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int IW         = 6,
  parameter int CW         = 7,
  parameter int CELL_INDEX = 0
) (
  input  logic                  clk,
  input  cell_op_t              op,
  input  logic [IW-1:0]         idx,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [CW-1:0]         count,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] tail_data
);

  localparam logic [IW-1:0] MY_IDX  = IW'(CELL_INDEX);
  localparam logic [CW-1:0] MY_NEXT = CW'(CELL_INDEX + 1);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (op)
      CELL_INSERT: begin
        // cells behind the slot take their left neighbor
        if (MY_IDX > idx) begin
          data_nxt = left_data;
        end else if (MY_IDX == idx) begin
          data_nxt = value;
        end
      end
      CELL_REMOVE: begin
        if (MY_IDX >= idx) begin
          data_nxt = right_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data      = data_r;
  assign tail_data = (count == MY_NEXT) ? data_r : '0;

endmodule

### src/pldq_chain.sv
// Row of list cells with front tap and last-cell select.
module pldq_chain import pldq_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  parameter int IW         = 6,
  parameter int CW         = 7
) (
  input  logic                  clk,
  input  cell_op_t              op,
  input  logic [IW-1:0]         idx,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [CW-1:0]         count,
  output logic [DATA_WIDTH-1:0] front_data,
  output logic [DATA_WIDTH-1:0] back_data
);

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_tail [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;

    if (g == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    pldq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IW         (IW),
      .CW         (CW),
      .CELL_INDEX (g)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .idx        (idx),
      .value      (value),
      .count      (count),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[g]),
      .tail_data  (cell_tail[g])
    );
  end

  // at most one cell flags itself as the last one
  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_data = back_data | cell_tail[i];
    end
  end

  assign front_data = cell_data[0];

endmodule

### src/positional_list_deque_unit.sv
// Top level of the positional list deque unit.
//
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------------
//  in      | in_valid, in_ready, in_data    | one request (type, position, value)
//  out     | out_valid, out_ready, out_data | one result (status, ends, count)
//
// For each request the cell row shifts in the accept cycle, and the result
// state then gathers front, back and count into the output register.
// The back value comes from an OR over all cells, one per cell select.
// Reset empties the list; cell contents are not cleared.
// A stalled output holds the block in its result cycle; a request may be
// accepted while an earlier result still waits to be taken.
`include "positional_list_deque_unit_assert.svh"

module positional_list_deque_unit import pldq_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_data
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IW    = $clog2(DEPTH);
  localparam int CMP_W = ((CW > 8) ? CW : 8) + 1;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  status_t         status_r, status_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_rsp_t        out_data_r, out_data_nxt;

  logic            in_acc;
  logic            load_out;
  cell_op_t        req_op, cell_op;
  logic [IW-1:0]   req_idx;
  logic            grow, shrink;
  logic [63:0]     val_ext;
  logic [DATA_WIDTH-1:0] cell_value;
  logic [DATA_WIDTH-1:0] front_data, back_data;
  logic [63:0]     front_ext, back_ext;

  // request decode
  always_comb begin
    logic [CMP_W-1:0] cnt_w;
    logic [CMP_W-1:0] pos_w;
    logic             full;
    logic             empty;
    cnt_w      = CMP_W'(count_r);
    pos_w      = CMP_W'(in_data.position);
    full       = (count_r == CW'(DEPTH));
    empty      = (count_r == '0);
    req_op     = CELL_HOLD;
    req_idx    = '0;
    status_nxt = ST_OK;
    grow       = 1'b0;
    shrink     = 1'b0;
    unique case (req_t'(in_data.req_type))
      REQ_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          req_op = CELL_INSERT;
          grow   = 1'b1;
        end
      end
      REQ_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          req_op  = CELL_INSERT;
          req_idx = IW'(count_r);
          grow    = 1'b1;
        end
      end
      REQ_INSERT: begin
        if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
          status_nxt = ST_BADPOS;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          req_op  = CELL_INSERT;
          req_idx = IW'(pos_w - CMP_W'(1));
          grow    = 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          req_op = CELL_REMOVE;
          shrink = 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          req_op  = CELL_REMOVE;
          req_idx = IW'(count_r - CW'(1));
          shrink  = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (pos_w == '0 || pos_w > cnt_w) begin
          status_nxt = ST_BADPOS;
        end else begin
          req_op  = CELL_REMOVE;
          req_idx = IW'(pos_w - CMP_W'(1));
          shrink  = 1'b1;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_RESULT: begin
        load_out = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_acc     = in_valid && in_ready;
  assign cell_op    = in_acc ? req_op : CELL_HOLD;
  assign val_ext    = 64'($signed(in_data.item_value));
  assign cell_value = val_ext[DATA_WIDTH-1:0];

  always_comb begin
    count_nxt = count_r;
    if (in_acc && grow) begin
      count_nxt = count_r + CW'(1);
    end else if (in_acc && shrink) begin
      count_nxt = count_r - CW'(1);
    end
  end

  pldq_chain #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IW         (IW),
    .CW         (CW)
  ) u_chain (
    .clk        (clk),
    .op         (cell_op),
    .idx        (req_idx),
    .value      (cell_value),
    .count      (count_r),
    .front_data (front_data),
    .back_data  (back_data)
  );

  assign front_ext = 64'($signed(front_data));
  assign back_ext  = 64'($signed(back_data));

  always_comb begin
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.status      = status_r;
      out_data_nxt.front_value = (count_r == '0) ? '0 : front_ext[31:0];
      out_data_nxt.back_value  = back_ext[31:0];
      out_data_nxt.count       = 7'(count_r);
      out_data_nxt.is_empty    = (count_r == '0);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= status_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PLDQ_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "count above depth")
  `PLDQ_ASSERT_NEXT(a_count_idle, !in_acc, $stable(count_r), "count moved without a request")
  `PLDQ_ASSERT_NEXT(a_count_err, in_acc && status_nxt != ST_OK, $stable(count_r), "count moved on a refused request")
  `PLDQ_ASSERT_NEXT(a_accept_result, in_acc, state_r == S_RESULT && !in_ready, "no result cycle after request")
  `PLDQ_ASSERT_IMPL(a_empty_flag, out_valid_r, out_data_r.is_empty == (out_data_r.count == 7'd0), "empty flag mismatch")

endmodule

### dv/positional_list_deque_unit_test.sv
// Self-checking testbench for the positional list deque unit.
module positional_list_deque_unit_test import pldq_pkg::*;;

  localparam int LIST_DEPTH = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int ITEMS_PER_PHASE = 185;

  // Request codes the block leaves unused
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  typedef enum int {MIX_FILL, MIX_EVEN, MIX_DRAIN} mix_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_data;

  in_req_t           pending_reqs[$];
  out_rsp_t          expected_rsps[$];
  logic signed [31:0] list_vals[$];

  int planned_fill = 0;
  int issued_total = 0;
  int checked_total = 0;
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int cycle_count = 0;

  positional_list_deque_unit #(
    .DEPTH(LIST_DEPTH),
    .DATA_WIDTH(32)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one request to the list and return the result it should give.
  function automatic out_rsp_t deque_apply(in_req_t r);
    out_rsp_t rsp;
    int       n;
    int       p;
    n = list_vals.size();
    p = int'(r.position);
    rsp = '0;
    rsp.status = ST_OK;
    case (r.req_type)
      REQ_PUSH_FRONT: begin
        if (n >= LIST_DEPTH) rsp.status = ST_FULL;
        else list_vals.push_front(r.item_value);
      end
      REQ_PUSH_BACK: begin
        if (n >= LIST_DEPTH) rsp.status = ST_FULL;
        else list_vals.push_back(r.item_value);
      end
      REQ_INSERT: begin
        // position range is checked before fullness
        if (p < 1 || p > n + 1) rsp.status = ST_BADPOS;
        else if (n >= LIST_DEPTH) rsp.status = ST_FULL;
        else list_vals.insert(p - 1, r.item_value);
      end
      REQ_POP_FRONT: begin
        if (n == 0) rsp.status = ST_EMPTY;
        else void'(list_vals.pop_front());
      end
      REQ_POP_BACK: begin
        if (n == 0) rsp.status = ST_EMPTY;
        else void'(list_vals.pop_back());
      end
      REQ_REMOVE: begin
        if (p < 1 || p > n) rsp.status = ST_BADPOS;
        else list_vals.delete(p - 1);
      end
      default: ;
    endcase
    n = list_vals.size();
    rsp.count = n[6:0];
    rsp.is_empty = (n == 0);
    if (n != 0) begin
      rsp.front_value = list_vals[0];
      rsp.back_value = list_vals[n - 1];
    end
    return rsp;
  endfunction

  // Queue a request and track the fill level it will leave behind.
  task automatic queue_req(logic [2:0] kind, logic [7:0] pos, logic signed [31:0] val);
    in_req_t r;
    int      p;
    r.req_type = kind;
    r.position = pos;
    r.item_value = val;
    p = int'(pos);
    case (kind)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (planned_fill < LIST_DEPTH) planned_fill++;
      end
      REQ_INSERT: begin
        if (p >= 1 && p <= planned_fill + 1 && planned_fill < LIST_DEPTH) planned_fill++;
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (planned_fill > 0) planned_fill--;
      end
      REQ_REMOVE: begin
        if (p >= 1 && p <= planned_fill) planned_fill--;
      end
      default: ;
    endcase
    pending_reqs.push_back(r);
    issued_total++;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Pick a position: mostly in range, otherwise zero, one past top or any byte.
  function automatic logic [7:0] pick_pos(int top);
    if (top >= 1 && $urandom_range(99) < 80) return 8'($urandom_range(top, 1));
    case ($urandom_range(2))
      0: return '0;
      1: return (top + 1 > 255) ? 8'd255 : 8'(top + 1);
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic plan_random(int n_items);
    int         left;
    int         seg;
    int         grow_pct;
    int         seg_index;
    mix_t       mode;
    logic [2:0] kind;
    left = n_items;
    seg_index = 0;
    while (left > 0) begin
      mode = mix_t'(seg_index % 3);
      seg = (mode == MIX_FILL) ? $urandom_range(140, 100) : $urandom_range(80, 30);
      grow_pct = (mode == MIX_FILL) ? 85 : (mode == MIX_DRAIN) ? 15 : 50;
      for (int i = 0; i < seg && left > 0; i++) begin
        if ($urandom_range(99) < 6) begin
          // noise: any code, any position
          queue_req(3'($urandom_range(7)), 8'($urandom_range(255)), pick_value());
        end else if ($urandom_range(99) < grow_pct) begin
          kind = $urandom_range(2) == 0 ? REQ_PUSH_FRONT :
                 $urandom_range(1) == 0 ? REQ_PUSH_BACK : REQ_INSERT;
          queue_req(kind, pick_pos(planned_fill + 1), pick_value());
        end else begin
          kind = $urandom_range(2) == 0 ? REQ_POP_FRONT :
                 $urandom_range(1) == 0 ? REQ_POP_BACK : REQ_REMOVE;
          queue_req(kind, pick_pos(planned_fill), pick_value());
        end
        left--;
      end
      seg_index++;
    end
  endtask

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      error_count++;
    end
  endtask

  task automatic wait_settled();
    while (checked_total != issued_total) @(posedge clk);
  endtask

  // Sender: hold the request until taken, then offer the next one or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!in_valid || in_ready) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_requests) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    out_rsp_t want;
    if (rst_n) begin
      if (in_valid && in_ready) expected_rsps.push_back(deque_apply(in_data));
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          want = expected_rsps.pop_front();
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("front_value", want.front_value, out_data.front_value);
          check_field("back_value", want.back_value, out_data.back_value);
          check_field("count", 32'(want.count), 32'(out_data.count));
          check_field("is_empty", 32'(want.is_empty), 32'(out_data.is_empty));
        end
        checked_total++;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[positional_list_deque_unit] ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: pops, removes and bad inserts
    queue_req(REQ_POP_FRONT, 8'd0, '0);
    queue_req(REQ_POP_BACK, 8'd0, '0);
    queue_req(REQ_REMOVE, 8'd1, '0);
    queue_req(REQ_REMOVE, 8'd0, '0);
    queue_req(REQ_INSERT, 8'd0, 32'sd5);
    queue_req(REQ_INSERT, 8'd2, 32'sd6);
    // grow with extreme values
    queue_req(REQ_INSERT, 8'd1, VAL_MIN);
    queue_req(REQ_PUSH_BACK, 8'd0, VAL_MAX);
    queue_req(REQ_PUSH_FRONT, 8'd0, -32'sd1);
    queue_req(REQ_PUSH_FRONT, 8'd200, '0);
    queue_req(REQ_INSERT, 8'd5, 32'sh5a5a_5a5a);
    queue_req(REQ_INSERT, 8'd3, 32'sh1234_5678);
    queue_req(REQ_INSERT, 8'd8, 32'sd9);
    queue_req(REQ_INSERT, 8'd255, 32'sd10);
    queue_req(REQ_SPARE_LO, 8'd3, 32'sh0bad_cafe);
    queue_req(REQ_SPARE_HI, 8'd255, VAL_MIN);
    // shrink: middle, last, past the end
    queue_req(REQ_REMOVE, 8'd3, '0);
    queue_req(REQ_REMOVE, 8'd5, '0);
    queue_req(REQ_REMOVE, 8'd5, '0);
    queue_req(REQ_REMOVE, 8'd255, '0);
    queue_req(REQ_POP_FRONT, 8'd0, '0);
    queue_req(REQ_POP_BACK, 8'd0, '0);
    queue_req(REQ_POP_FRONT, 8'd0, '0);
    queue_req(REQ_POP_BACK, 8'd0, '0);
    queue_req(REQ_POP_BACK, 8'd0, '0);
    wait_settled();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      plan_random(ITEMS_PER_PHASE);
      // back up the block while requests keep coming
      if (ph == 0) hold_requests++;
      wait_settled();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("[positional_list_deque_unit] OK");
    end else begin
      $display("[positional_list_deque_unit] ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/pldq_pkg.sv
src/pldq_cell.sv
src/pldq_chain.sv
src/positional_list_deque_unit.sv
dv/positional_list_deque_unit_test.sv
